// ===== rtl/asp_pkg.sv =====
// Shared types, constants and cost helpers for the A* path planner.
// No dependencies; imported by asp_dist and astar_path_planner_top.
package asp_pkg;

  localparam int NUM_NODES  = 16;
  localparam int IDX_W      = $clog2(NUM_NODES);
  localparam int LEN_W      = IDX_W + 1;
  localparam int COORD_W    = 10;
  localparam int MASK_W     = 16;
  localparam int COST_W     = 21;
  localparam int PAR_W      = 5;
  localparam int DIST_W     = 15;

  localparam logic [COST_W-1:0] COST_INF  = {COST_W{1'b1}};
  localparam logic [PAR_W-1:0]  NO_PARENT = {PAR_W{1'b1}};

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SOLVE = 1'b1;

  // Operands of one distance request
  typedef struct packed {
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
  } dist_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [MASK_W-1:0]  adj;
    logic               obst;
  } node_t;

  typedef struct packed {
    logic [PAR_W-1:0]  parent;
    logic [COST_W-1:0] total;
    logic [COST_W-1:0] local_c;
  } cost_t;

  // Saturating add; all ones means infinity
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, COST_INF}) begin
      return COST_INF;
    end
    return s[COST_W-1:0];
  endfunction

endpackage

// ===== rtl/asp_dist.sv =====
// Euclidean distance unit in Q.4: floor(sqrt(256*(dx^2+dy^2))).
// Squares the differences and sums them, then computes a two-bit-per-step iterative root;
// done pulses when the root is complete. Uses asp_pkg.
module asp_dist import asp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dist_req_t         req,
  output logic              done,
  output logic [DIST_W-1:0] root_out
);

  localparam int VW        = 30;
  localparam int ITERS     = 15;
  localparam int STEP_W    = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ITERS + 1);

  logic                     busy_r;
  logic                     done_r;
  logic [STEP_W-1:0]        step_r;
  logic signed [COORD_W:0]  dx_r, dy_r;
  logic [2*COORD_W-1:0]     sqx_r, sqy_r;
  logic [VW-1:0]            v_r, root_r, bit_r;

  logic signed [2*COORD_W+1:0] px, py;
  logic [2*COORD_W:0]          sum;
  logic [VW-1:0]               trial;

  assign px    = dx_r * dx_r;
  assign py    = dy_r * dy_r;
  assign sum   = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign trial = root_r + bit_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dx_r <= $signed({1'b0, req.ax}) - $signed({1'b0, req.bx});
      dy_r <= $signed({1'b0, req.ay}) - $signed({1'b0, req.by});
    end else if (busy_r) begin
      if (step_r == '0) begin
        sqx_r <= px[2*COORD_W-1:0];
        sqy_r <= py[2*COORD_W-1:0];
      end else if (step_r == STEP_W'(1)) begin
        v_r    <= {1'b0, sum, 8'b0};
        root_r <= '0;
        bit_r  <= VW'(1) << (VW - 2);
      end else begin
        if (v_r >= trial) begin
          v_r    <= v_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

  assign done     = done_r;
  assign root_out = root_r[DIST_W-1:0];

endmodule

// ===== rtl/astar_path_planner_top.sv =====
// A* path planner top level: node and cost memories, search sequencer, path output.
// Depends on asp_pkg and asp_dist.
//
// Usage: requests enter on in_valid/in_ready. A load request (kind 0) writes one
// node (coordinates, neighbor mask, obstacle flag) and gives no result.
// A solve request (kind 1) searches from start_node to goal_node and returns the
// path on out_valid/out_ready, start first, last set on the goal; reached is 0 with
// only the goal returned when the goal cannot be reached.
// Throughput: one request at a time; in_ready is high only while idle. A solve
// reads the goal and start nodes and computes the start heuristic, then for each
// expanded node scans every cost entry for the least open total, loads and closes
// it, scans its neighbor indices and per neighbor computes one or two distances in
// the shared iterative root unit, then walks the parent links and emits each node,
// waiting on receiver stall.
// Reset clears node valid bits (mask and obstacle read as zero), the state and the flags;
// search state is cleared at each solve by per-entry valid bits, no sweep.
// A stalled receiver holds the output register; the sequencer waits for it.
module astar_path_planner_top import asp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [IDX_W-1:0]   in_node_index,
  input  logic [COORD_W-1:0] in_coord_x,
  input  logic [COORD_W-1:0] in_coord_y,
  input  logic [MASK_W-1:0]  in_neighbor_mask,
  input  logic               in_blocked,
  input  logic [IDX_W-1:0]   in_start_node,
  input  logic [IDX_W-1:0]   in_goal_node,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   out_path_node,
  output logic               out_last,
  output logic               out_reached
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE    = 5'd0;
  localparam logic [ST_W-1:0] S_RDG     = 5'd1;
  localparam logic [ST_W-1:0] S_RDS     = 5'd2;
  localparam logic [ST_W-1:0] S_INIT    = 5'd3;
  localparam logic [ST_W-1:0] S_INITW   = 5'd4;
  localparam logic [ST_W-1:0] S_SEL_RD  = 5'd5;
  localparam logic [ST_W-1:0] S_SEL_CMP = 5'd6;
  localparam logic [ST_W-1:0] S_CUR_RD  = 5'd7;
  localparam logic [ST_W-1:0] S_CUR     = 5'd8;
  localparam logic [ST_W-1:0] S_NB      = 5'd9;
  localparam logic [ST_W-1:0] S_NB_D    = 5'd10;
  localparam logic [ST_W-1:0] S_NB_W1   = 5'd11;
  localparam logic [ST_W-1:0] S_NB_W2   = 5'd12;
  localparam logic [ST_W-1:0] S_NB_NEXT = 5'd13;
  localparam logic [ST_W-1:0] S_EXP_END = 5'd14;
  localparam logic [ST_W-1:0] S_PW0     = 5'd15;
  localparam logic [ST_W-1:0] S_PW1     = 5'd16;
  localparam logic [ST_W-1:0] S_EM_RD   = 5'd17;
  localparam logic [ST_W-1:0] S_EM_LD   = 5'd18;
  localparam logic [ST_W-1:0] S_EM_W    = 5'd19;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_NODES - 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(NUM_NODES);

  logic [ST_W-1:0]       state_r;
  logic [IDX_W-1:0]      start_r, goal_r, cur_r, idx_r, best_r;
  logic [COORD_W-1:0]    goal_x_r, goal_y_r, cur_x_r, cur_y_r, nb_x_r, nb_y_r;
  logic [MASK_W-1:0]     cur_adj_r;
  logic [COST_W-1:0]     cur_local_r, best_cost_r, best_local_r, nb_local_r, cand_r;
  logic                  found_r;
  logic [NUM_NODES-1:0]  visited_r, open_r, cvalid_r, nvalid_r;
  logic [LEN_W-1:0]      len_r, k_r;
  logic                  out_valid_r, out_last_r, out_reached_r;
  logic [IDX_W-1:0]      out_node_r;

  // memories
  node_t            node_mem [NUM_NODES];
  cost_t            cost_mem [NUM_NODES];
  logic [IDX_W-1:0] pbuf_mem [NUM_NODES];

  node_t            node_q, node_eff;
  logic             nvalid_q;
  cost_t            cost_q, cost_eff;
  logic             cvalid_q;
  logic [IDX_W-1:0] pbuf_q;

  logic             in_fire;
  logic [IDX_W-1:0] node_raddr, cost_raddr, cost_waddr, pbuf_raddr, pbuf_waddr;
  logic             cost_we, pbuf_we;
  cost_t            cost_wdata;
  logic [IDX_W-1:0] pbuf_wdata;

  logic              dist_start, dist_done;
  dist_req_t         dist_req;
  logic [DIST_W-1:0] dist_val;
  logic [COST_W-1:0] dist_ext, cand_now;

  logic             take, parent_ok;
  logic [IDX_W-1:0] parent_idx;

  asp_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dist_start),
    .req      (dist_req),
    .done     (dist_done),
    .root_out (dist_val)
  );

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign dist_ext = COST_W'(dist_val);
  assign cand_now = sat_add(cur_local_r, dist_ext);

  // invalid entries read as their reset value
  always_comb begin
    node_eff = node_q;
    if (!nvalid_q) begin
      node_eff.adj  = '0;
      node_eff.obst = 1'b0;
    end
    cost_eff = cost_q;
    if (!cvalid_q) begin
      cost_eff.parent  = NO_PARENT;
      cost_eff.total   = COST_INF;
      cost_eff.local_c = COST_INF;
    end
  end

  assign take = open_r[idx_r] && !visited_r[idx_r] &&
                (!found_r || (cost_eff.total < best_cost_r));
  assign parent_ok  = (cost_eff.parent != NO_PARENT) && (len_r != LEN_FULL);
  assign parent_idx = cost_eff.parent[IDX_W-1:0];

  // read addresses, write strobes and distance requests
  always_comb begin
    node_raddr = idx_r;
    cost_raddr = idx_r;
    pbuf_raddr = IDX_W'(len_r - LEN_W'(1) - k_r);
    cost_we    = 1'b0;
    cost_waddr = idx_r;
    cost_wdata = '{parent: {1'b0, cur_r}, total: sat_add(cand_r, dist_ext),
                   local_c: cand_r};
    pbuf_we    = 1'b0;
    pbuf_waddr = len_r[IDX_W-1:0];
    pbuf_wdata = parent_idx;
    dist_start = 1'b0;
    dist_req   = '{ax: cur_x_r, ay: cur_y_r, bx: goal_x_r, by: goal_y_r};
    case (state_r)
      S_RDG:    node_raddr = goal_r;
      S_RDS:    node_raddr = start_r;
      S_INIT: begin
        dist_start = 1'b1;
        dist_req   = '{ax: node_eff.x, ay: node_eff.y, bx: goal_x_r, by: goal_y_r};
      end
      S_INITW: begin
        cost_we    = dist_done;
        cost_waddr = start_r;
        cost_wdata = '{parent: NO_PARENT, total: dist_ext, local_c: '0};
      end
      S_CUR_RD: node_raddr = cur_r;
      S_NB_D: begin
        dist_start = 1'b1;
        dist_req   = '{ax: cur_x_r, ay: cur_y_r, bx: node_eff.x, by: node_eff.y};
      end
      S_NB_W1: begin
        dist_start = dist_done && (cand_now < nb_local_r);
        dist_req   = '{ax: nb_x_r, ay: nb_y_r, bx: goal_x_r, by: goal_y_r};
      end
      S_NB_W2: cost_we = dist_done;
      S_PW0: begin
        cost_raddr = goal_r;
        pbuf_we    = 1'b1;
        pbuf_waddr = '0;
        pbuf_wdata = goal_r;
      end
      S_PW1: begin
        cost_raddr = parent_idx;
        pbuf_we    = parent_ok;
      end
      default: ;
    endcase
  end

  // node memory: written by load requests
  always_ff @(posedge clk) begin
    if (in_fire && (in_kind == KIND_LOAD)) begin
      node_mem[in_node_index] <= '{x: in_coord_x, y: in_coord_y,
                                   adj: in_neighbor_mask, obst: in_blocked};
    end
    node_q   <= node_mem[node_raddr];
    nvalid_q <= nvalid_r[node_raddr];
  end

  // cost memory: parent, total and local cost per node
  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    cost_q   <= cost_mem[cost_raddr];
    cvalid_q <= cvalid_r[cost_raddr];
  end

  // path buffer
  always_ff @(posedge clk) begin
    if (pbuf_we) begin
      pbuf_mem[pbuf_waddr] <= pbuf_wdata;
    end
    pbuf_q <= pbuf_mem[pbuf_raddr];
  end

  // search sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nvalid_r    <= '0;
      cvalid_r    <= '0;
      visited_r   <= '0;
      open_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cost_we) begin
        cvalid_r[cost_waddr] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_kind == KIND_LOAD) begin
              nvalid_r[in_node_index] <= 1'b1;
            end else begin
              start_r   <= in_start_node;
              goal_r    <= in_goal_node;
              visited_r <= '0;
              open_r    <= '0;
              cvalid_r  <= '0;
              if (in_start_node == in_goal_node) begin
                out_node_r    <= in_goal_node;
                out_last_r    <= 1'b1;
                out_reached_r <= 1'b1;
                out_valid_r   <= 1'b1;
                state_r       <= S_EM_W;
              end else begin
                state_r <= S_RDG;
              end
            end
          end
        end
        S_RDG: state_r <= S_RDS;
        S_RDS: begin
          goal_x_r <= node_eff.x;
          goal_y_r <= node_eff.y;
          state_r  <= S_INIT;
        end
        S_INIT: state_r <= S_INITW;
        S_INITW: begin
          if (dist_done) begin
            open_r[start_r] <= 1'b1;
            idx_r           <= '0;
            found_r         <= 1'b0;
            state_r         <= S_SEL_RD;
          end
        end
        // scan open nodes for the least total cost
        S_SEL_RD: state_r <= S_SEL_CMP;
        S_SEL_CMP: begin
          if (take) begin
            found_r      <= 1'b1;
            best_r       <= idx_r;
            best_cost_r  <= cost_eff.total;
            best_local_r <= cost_eff.local_c;
          end
          if (idx_r == IDX_LAST) begin
            if (!(found_r || take)) begin
              state_r <= S_PW0;
            end else begin
              cur_r       <= take ? idx_r : best_r;
              cur_local_r <= take ? cost_eff.local_c : best_local_r;
              visited_r[take ? idx_r : best_r] <= 1'b1;
              open_r[take ? idx_r : best_r]    <= 1'b0;
              state_r <= S_CUR_RD;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SEL_RD;
          end
        end
        S_CUR_RD: state_r <= S_CUR;
        S_CUR: begin
          cur_x_r   <= node_eff.x;
          cur_y_r   <= node_eff.y;
          cur_adj_r <= node_eff.adj;
          idx_r     <= '0;
          state_r   <= S_NB;
        end
        // relax neighbors in ascending index
        S_NB: begin
          if (cur_adj_r[idx_r]) begin
            state_r <= S_NB_D;
          end else if (idx_r == IDX_LAST) begin
            state_r <= S_EXP_END;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_NB_D: begin
          nb_x_r     <= node_eff.x;
          nb_y_r     <= node_eff.y;
          nb_local_r <= cost_eff.local_c;
          if (!visited_r[idx_r] && !node_eff.obst) begin
            open_r[idx_r] <= 1'b1;
          end
          state_r <= S_NB_W1;
        end
        S_NB_W1: begin
          if (dist_done) begin
            cand_r  <= cand_now;
            state_r <= (cand_now < nb_local_r) ? S_NB_W2 : S_NB_NEXT;
          end
        end
        S_NB_W2: begin
          if (dist_done) begin
            state_r <= S_NB_NEXT;
          end
        end
        S_NB_NEXT: begin
          if (idx_r == IDX_LAST) begin
            state_r <= S_EXP_END;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_NB;
          end
        end
        S_EXP_END: begin
          idx_r   <= '0;
          found_r <= 1'b0;
          state_r <= (cur_r == goal_r) ? S_PW0 : S_SEL_RD;
        end
        // walk the parent chain back from the goal
        S_PW0: begin
          len_r   <= LEN_W'(1);
          state_r <= S_PW1;
        end
        S_PW1: begin
          if (parent_ok) begin
            len_r <= len_r + 1'b1;
          end else if (len_r == LEN_W'(1)) begin
            out_node_r    <= goal_r;
            out_last_r    <= 1'b1;
            out_reached_r <= 1'b0;
            out_valid_r   <= 1'b1;
            state_r       <= S_EM_W;
          end else begin
            k_r     <= '0;
            state_r <= S_EM_RD;
          end
        end
        // emit buffered path start first
        S_EM_RD: state_r <= S_EM_LD;
        S_EM_LD: begin
          out_node_r    <= pbuf_q;
          out_last_r    <= (k_r == len_r - LEN_W'(1));
          out_reached_r <= 1'b1;
          out_valid_r   <= 1'b1;
          state_r       <= S_EM_W;
        end
        S_EM_W: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_EM_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_path_node = out_node_r;
  assign out_last      = out_last_r;
  assign out_reached   = out_reached_r;

endmodule

// ===== dv/astar_path_planner_top_tb.sv =====
// Self-checking testbench for astar_path_planner_top: node loads and path solves.
// Depends on asp_pkg and the planner RTL; predicts each path with its own A* search.
module astar_path_planner_top_tb;
  import asp_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] node;
    logic             last;
    logic             reached;
  } path_step_t;

  // Path predictor and scoreboard
  class path_scoreboard;
    localparam int unsigned CAP = int'(COST_INF);

    int unsigned        x_pos[NUM_NODES];
    int unsigned        y_pos[NUM_NODES];
    logic [MASK_W-1:0]  adj[NUM_NODES];
    bit                 obst[NUM_NODES];
    path_step_t         exp_path[$];
    int                 mismatches;

    function new();
      for (int i = 0; i < NUM_NODES; i++) begin
        x_pos[i] = 0; y_pos[i] = 0; adj[i] = '0; obst[i] = 0;
      end
      mismatches = 0;
    endfunction

    function int unsigned int_sqrt(int unsigned v);
      int unsigned root;
      int unsigned b;
      root = 0;
      b = 32'h4000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v = v - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    // Euclidean distance in Q.4
    function int unsigned edge_len(int a, int b);
      int dx;
      int dy;
      dx = int'(x_pos[a]) - int'(x_pos[b]);
      dy = int'(y_pos[a]) - int'(y_pos[b]);
      return int_sqrt((dx * dx + dy * dy) * 256);
    endfunction

    function int unsigned cost_add(int unsigned a, int unsigned b);
      return (a + b > CAP) ? CAP : a + b;
    endfunction

    function void note_request(logic kind, logic [IDX_W-1:0] idx, logic [COORD_W-1:0] cx,
                               logic [COORD_W-1:0] cy, logic [MASK_W-1:0] mask, logic blk,
                               logic [IDX_W-1:0] start, logic [IDX_W-1:0] goal);
      bit          visited[NUM_NODES];
      bit          opened[NUM_NODES];
      int unsigned g_cost[NUM_NODES];
      int unsigned f_cost[NUM_NODES];
      int          parent[NUM_NODES];
      int          chain[$];
      int          cur;
      int          best;
      int          p;
      int          st;
      int          gl;
      int unsigned best_cost;
      int unsigned cand;
      path_step_t  s;
      if (kind == KIND_LOAD) begin
        x_pos[idx] = int'(cx); y_pos[idx] = int'(cy); adj[idx] = mask; obst[idx] = blk;
        return;
      end
      st = int'(start);
      gl = int'(goal);
      for (int i = 0; i < NUM_NODES; i++) begin
        visited[i] = 0; opened[i] = 0;
        g_cost[i] = CAP; f_cost[i] = CAP; parent[i] = -1;
      end
      g_cost[st] = 0;
      f_cost[st] = (edge_len(st, gl) > CAP) ? CAP : edge_len(st, gl);
      opened[st] = 1;
      cur = st;
      while (cur != gl) begin
        best = -1;
        best_cost = 0;
        for (int i = 0; i < NUM_NODES; i++) begin
          if (opened[i] && !visited[i] && (best < 0 || f_cost[i] < best_cost)) begin
            best = i;
            best_cost = f_cost[i];
          end
        end
        if (best < 0) break;
        cur = best;
        visited[cur] = 1;
        opened[cur] = 0;
        for (int j = 0; j < NUM_NODES; j++) begin
          if (adj[cur][j]) begin
            if (!visited[j] && !obst[j]) opened[j] = 1;
            cand = cost_add(g_cost[cur], edge_len(cur, j));
            if (cand < g_cost[j]) begin
              parent[j] = cur;
              g_cost[j] = cand;
              f_cost[j] = cost_add(cand, edge_len(j, gl));
            end
          end
        end
      end
      // unreachable goal: goal alone, flagged
      if (gl != st && parent[gl] < 0) begin
        s.node = goal; s.last = 1; s.reached = 0;
        exp_path.insert(exp_path.size(), s);
        return;
      end
      p = gl;
      chain.push_front(p);
      while (parent[p] >= 0 && chain.size() < NUM_NODES) begin
        p = parent[p];
        chain.push_front(p);
      end
      foreach (chain[k]) begin
        s.node = IDX_W'(chain[k]); s.last = (k == chain.size() - 1); s.reached = 1;
        exp_path.insert(exp_path.size(), s);
      end
    endfunction

    function void check_step(logic [IDX_W-1:0] node, logic last, logic reached);
      path_step_t e;
      if (exp_path.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected path step node=%0d last=%0b reached=%0b",
                   node, last, reached);
        return;
      end
      e = exp_path[0];
      exp_path.delete(0);
      if (node !== e.node || last !== e.last || reached !== e.reached) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: path step exp node=%0d last=%0b reached=%0b got %0d %0b %0b",
                   e.node, e.last, e.reached, node, last, reached);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_kind;
  logic [IDX_W-1:0]   in_node_index;
  logic [COORD_W-1:0] in_coord_x;
  logic [COORD_W-1:0] in_coord_y;
  logic [MASK_W-1:0]  in_neighbor_mask;
  logic               in_blocked;
  logic [IDX_W-1:0]   in_start_node;
  logic [IDX_W-1:0]   in_goal_node;
  logic               out_valid;
  logic               out_ready;
  logic [IDX_W-1:0]   out_path_node;
  logic               out_last;
  logic               out_reached;

  path_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  int  stall_cycles;

  astar_path_planner_top dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Receiver readiness
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_step(out_path_node, out_last, out_reached);
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 60000) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(logic kind, logic [IDX_W-1:0] idx, logic [COORD_W-1:0] cx,
                              logic [COORD_W-1:0] cy, logic [MASK_W-1:0] mask,
                              logic blk, logic [IDX_W-1:0] start, logic [IDX_W-1:0] goal);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_kind <= kind; in_node_index <= idx; in_coord_x <= cx; in_coord_y <= cy;
    in_neighbor_mask <= mask; in_blocked <= blk; in_start_node <= start;
    in_goal_node <= goal;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, idx, cx, cy, mask, blk, start, goal);
  endtask

  task automatic load_node(int idx, int cx, int cy, int mask, bit blk);
    send_request(KIND_LOAD, IDX_W'(idx), COORD_W'(cx), COORD_W'(cy), MASK_W'(mask), blk,
                 IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic solve_path(int start, int goal);
    send_request(KIND_SOLVE, IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                 MASK_W'($urandom), 1'($urandom), IDX_W'(start), IDX_W'(goal));
  endtask

  task automatic random_request();
    if ($urandom_range(99) < 35) begin
      load_node($urandom_range(15), $urandom_range(1023), $urandom_range(1023),
                ($urandom_range(3) == 0) ? int'($urandom) : int'($urandom & $urandom),
                $urandom_range(5) == 0);
    end else begin
      solve_path($urandom_range(15), $urandom_range(15));
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_kind = 0; in_node_index = 0; in_coord_x = 0; in_coord_y = 0;
    in_neighbor_mask = 0; in_blocked = 0; in_start_node = 0; in_goal_node = 0;
    send_idle_pct = 9;
    recv_idle_pct = 63;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // Every node gets coordinates before any solve; corners and extremes first
    load_node(0, 0, 0, 16'h0002, 0);
    load_node(1, 1023, 1023, 16'hFFFF, 0);
    load_node(2, 1023, 0, 16'h0000, 0);
    load_node(3, 0, 1023, 16'h0010, 1);
    for (int i = 4; i < 16; i++)
      load_node(i, $urandom_range(1023), $urandom_range(1023), int'($urandom & $urandom), 0);
    solve_path(5, 5);           // start equals goal
    solve_path(0, 2);           // chain through a full mask
    solve_path(4, 2);           // goal with no outgoing edges
    solve_path(3, 4);           // obstacle start still expands
    solve_path(1, 3);           // obstacle goal can be reached
    load_node(2, 512, 300, 16'h0000, 1);
    solve_path(15, 0);

    // Random part in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < 40; n++) random_request();
      if (ph == 0) begin
        send_idle_pct = 63; recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
    end
    in_valid <= 1'b0;

    while (sb.exp_path.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.exp_path.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== astar_path_planner_top.f =====
rtl/asp_pkg.sv
rtl/asp_dist.sv
rtl/astar_path_planner_top.sv
dv/astar_path_planner_top_tb.sv
